### src/tbse_pkg.sv
// shared types and constants of the three-band stereo equalizer
// controller command and status words, register indexes, fixed widths
`default_nettype none

package tbse_pkg;

	// fixed field widths
	localparam int SAMPLE_W   = 16;
	localparam int ALPHA_W    = 16;
	localparam int GAIN_W     = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	// multiplier coefficient operand: unsigned alpha or gain with a zero sign bit
	localparam int COEF_W = 18;

	// fraction bits of alpha (Q0.16) and gain (Q3.14)
	localparam int ALPHA_FRAC = 16;
	localparam int GAIN_FRAC  = 14;

	// output scale 32767/32768 as (m << 15) - m then shift
	localparam int SCALE_BITS = 15;

	// saturation bounds
	localparam int SAT_POS_MAX = 32767;
	localparam int SAT_NEG_MAG = 32768;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_ALPHA   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_ALPHA  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TREBLE_GAIN = 3'd5;

	// register reset values
	localparam logic [ALPHA_W-1:0] LOW_ALPHA_RST  = 16'd2293;
	localparam logic [ALPHA_W-1:0] HIGH_ALPHA_RST = 16'd37657;
	localparam logic [GAIN_W-1:0]  GAIN_RST       = 17'd16384;

	// operand register source
	typedef enum logic [1:0] {
		OPND_X_BASS,
		OPND_X_UPPER,
		OPND_BASS,
		OPND_UPPER_BASS
	} opnd_sel_t;

	// multiplier coefficient source
	typedef enum logic [2:0] {
		COEF_LOW_ALPHA,
		COEF_HIGH_ALPHA,
		COEF_LOW_GAIN,
		COEF_MID_GAIN,
		COEF_TREBLE_GAIN
	} coef_sel_t;

	typedef struct packed {
		logic      ld;
		logic      ch;
		logic      opnd_en;
		opnd_sel_t opnd_sel;
		logic      mul_en;
		coef_sel_t coef_sel;
		logic      upd_bass;
		logic      upd_upper;
		logic      acc_clr;
		logic      acc_add;
		logic      mag_en;
		logic      scale_en;
		logic      sat_en;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic enable;
	} stat_t;

endpackage

`default_nettype wire

### src/tbse_ctrl.sv
// sequencer of the equalizer: accepts a word, if enabled steps the datapath
// through both channels, then hands it to the output register; uses tbse_pkg
`default_nettype none

module tbse_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire tbse_pkg::stat_t stat,
	output tbse_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	// step codes within one channel
	localparam logic [3:0] STEP_DIFF_BASS  = 4'd0;
	localparam logic [3:0] STEP_MUL_BASS   = 4'd1;
	localparam logic [3:0] STEP_UPD_BASS   = 4'd2;
	localparam logic [3:0] STEP_UPD_UPPER  = 4'd3;
	localparam logic [3:0] STEP_MUL_LOW    = 4'd4;
	localparam logic [3:0] STEP_MUL_MID    = 4'd5;
	localparam logic [3:0] STEP_MUL_HIGH   = 4'd6;
	localparam logic [3:0] STEP_ACC_LAST   = 4'd7;
	localparam logic [3:0] STEP_MAG        = 4'd8;
	localparam logic [3:0] STEP_SCALE      = 4'd9;
	localparam logic [3:0] STEP_SAT        = 4'd10;

	state_t     state_q;
	logic [3:0] step_q;
	logic       ch_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_DIFF_BASS;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new word replaces the one taken at this edge
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					step_q <= STEP_DIFF_BASS;
					ch_q   <= 1'b0;
					if (in_valid) begin
						state_q <= stat.enable ? ST_RUN : ST_DONE;
					end
				end
				ST_RUN: begin
					if (step_q == STEP_SAT) begin
						step_q <= STEP_DIFF_BASS;
						ch_q   <= 1'b1;
						if (ch_q) begin
							state_q <= ST_DONE;
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.ch       = ch_q;
		cmd.opnd_sel = tbse_pkg::OPND_X_BASS;
		cmd.coef_sel = tbse_pkg::COEF_LOW_ALPHA;
		case (state_q)
			ST_IDLE: begin
				cmd.ld = in_valid;
			end
			ST_RUN: begin
				case (step_q)
					STEP_DIFF_BASS: begin
						cmd.opnd_en  = 1'b1;
						cmd.opnd_sel = tbse_pkg::OPND_X_BASS;
					end
					STEP_MUL_BASS: begin
						cmd.mul_en   = 1'b1;
						cmd.coef_sel = tbse_pkg::COEF_LOW_ALPHA;
						cmd.opnd_en  = 1'b1;
						cmd.opnd_sel = tbse_pkg::OPND_X_UPPER;
					end
					STEP_UPD_BASS: begin
						cmd.upd_bass = 1'b1;
						cmd.mul_en   = 1'b1;
						cmd.coef_sel = tbse_pkg::COEF_HIGH_ALPHA;
					end
					STEP_UPD_UPPER: begin
						cmd.upd_upper = 1'b1;
						cmd.opnd_en   = 1'b1;
						cmd.opnd_sel  = tbse_pkg::OPND_BASS;
					end
					STEP_MUL_LOW: begin
						cmd.mul_en   = 1'b1;
						cmd.coef_sel = tbse_pkg::COEF_LOW_GAIN;
						cmd.opnd_en  = 1'b1;
						cmd.opnd_sel = tbse_pkg::OPND_UPPER_BASS;
					end
					STEP_MUL_MID: begin
						cmd.acc_clr  = 1'b1;
						cmd.mul_en   = 1'b1;
						cmd.coef_sel = tbse_pkg::COEF_MID_GAIN;
						cmd.opnd_en  = 1'b1;
						cmd.opnd_sel = tbse_pkg::OPND_X_UPPER;
					end
					STEP_MUL_HIGH: begin
						cmd.acc_add  = 1'b1;
						cmd.mul_en   = 1'b1;
						cmd.coef_sel = tbse_pkg::COEF_TREBLE_GAIN;
					end
					STEP_ACC_LAST: begin
						cmd.acc_add = 1'b1;
					end
					STEP_MAG: begin
						cmd.mag_en = 1'b1;
					end
					STEP_SCALE: begin
						cmd.scale_en = 1'b1;
					end
					STEP_SAT: begin
						cmd.sat_en = 1'b1;
					end
					default: begin
						cmd.ld = 1'b0;
					end
				endcase
			end
			ST_DONE: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd.ld = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

### src/tbse_dp.sv
// datapath of the equalizer: configuration registers, crossover state,
// one shared multiplier, accumulator, scale and saturation; uses tbse_pkg
`default_nettype none

module tbse_dp #(
	parameter int COEF_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [tbse_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [tbse_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic signed [tbse_pkg::SAMPLE_W-1:0] left_sample,
	input  wire logic signed [tbse_pkg::SAMPLE_W-1:0] right_sample,
	input  wire logic                                end_of_block,
	input  wire tbse_pkg::cmd_t                      cmd,
	output tbse_pkg::stat_t                          stat,
	output logic signed [tbse_pkg::SAMPLE_W-1:0]     left_result,
	output logic signed [tbse_pkg::SAMPLE_W-1:0]     right_result,
	output logic                                     end_of_block_out
);

	localparam int SW     = tbse_pkg::SAMPLE_W;
	localparam int X_W    = SW + COEF_BITS;
	localparam int LP_W   = X_W + 2;
	localparam int OPB_W  = LP_W + 1;
	localparam int PROD_W = tbse_pkg::COEF_W + OPB_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int SC_W   = ACC_W + tbse_pkg::SCALE_BITS;
	localparam int SAT_SH = tbse_pkg::GAIN_FRAC + tbse_pkg::SCALE_BITS + COEF_BITS;
	localparam int Q_W    = SC_W - SAT_SH;

	logic                              enable_q;
	logic [tbse_pkg::ALPHA_W-1:0]      low_alpha_q;
	logic [tbse_pkg::ALPHA_W-1:0]      high_alpha_q;
	logic [tbse_pkg::GAIN_W-1:0]       low_gain_q;
	logic [tbse_pkg::GAIN_W-1:0]       mid_gain_q;
	logic [tbse_pkg::GAIN_W-1:0]       treble_gain_q;

	logic signed [LP_W-1:0]            bass_q [2];
	logic signed [LP_W-1:0]            upper_q [2];

	logic signed [SW-1:0]              samp_l_q;
	logic signed [SW-1:0]              samp_r_q;
	logic                              eob_q;
	logic signed [SW-1:0]              res_l_q;
	logic signed [SW-1:0]              res_r_q;
	logic signed [OPB_W-1:0]           opnd_q;
	logic signed [PROD_W-1:0]          prod_q;
	logic signed [ACC_W-1:0]           acc_q;
	logic [ACC_W-1:0]                  mag_q;
	logic                              neg_q;
	logic [SC_W-1:0]                   sc_q;
	logic signed [SW-1:0]              left_q;
	logic signed [SW-1:0]              right_q;
	logic                              eob_out_q;

	logic signed [SW-1:0]              samp;
	logic signed [X_W-1:0]             x;
	logic signed [LP_W-1:0]            bass_cur;
	logic signed [LP_W-1:0]            upper_cur;
	logic signed [OPB_W-1:0]           opnd_d;
	logic signed [tbse_pkg::COEF_W-1:0] coef_d;
	logic signed [LP_W-1:0]            step_d;
	logic [Q_W-1:0]                    q;
	logic signed [SW-1:0]              sat_d;

	assign stat.enable      = enable_q;
	assign left_result      = left_q;
	assign right_result     = right_q;
	assign end_of_block_out = eob_out_q;

	assign samp      = cmd.ch ? samp_r_q : samp_l_q;
	assign x         = {samp, {COEF_BITS{1'b0}}};
	assign bass_cur  = bass_q[cmd.ch];
	assign upper_cur = upper_q[cmd.ch];

	// floor(alpha * diff / 2^16): dropping the low bits of a signed product
	assign step_d = $signed(prod_q[tbse_pkg::ALPHA_FRAC +: LP_W]);

	always_comb begin
		case (cmd.opnd_sel)
			tbse_pkg::OPND_X_BASS:     opnd_d = OPB_W'(x) - OPB_W'(bass_cur);
			tbse_pkg::OPND_X_UPPER:    opnd_d = OPB_W'(x) - OPB_W'(upper_cur);
			tbse_pkg::OPND_BASS:       opnd_d = OPB_W'(bass_cur);
			tbse_pkg::OPND_UPPER_BASS: opnd_d = OPB_W'(upper_cur) - OPB_W'(bass_cur);
			default:                   opnd_d = '0;
		endcase
	end

	always_comb begin
		case (cmd.coef_sel)
			tbse_pkg::COEF_LOW_ALPHA:   coef_d = $signed({2'b00, low_alpha_q});
			tbse_pkg::COEF_HIGH_ALPHA:  coef_d = $signed({2'b00, high_alpha_q});
			tbse_pkg::COEF_LOW_GAIN:    coef_d = $signed({1'b0, low_gain_q});
			tbse_pkg::COEF_MID_GAIN:    coef_d = $signed({1'b0, mid_gain_q});
			tbse_pkg::COEF_TREBLE_GAIN: coef_d = $signed({1'b0, treble_gain_q});
			default:                    coef_d = '0;
		endcase
	end

	// q = floor(|acc| * 32767 / 2^(29 + COEF_BITS)), then saturate
	assign q = sc_q[SC_W-1:SAT_SH];

	always_comb begin
		if (neg_q) begin
			if (q > Q_W'(tbse_pkg::SAT_NEG_MAG)) begin
				sat_d = SW'(-tbse_pkg::SAT_NEG_MAG);
			end else begin
				sat_d = -$signed(q[SW-1:0]);
			end
		end else begin
			if (q > Q_W'(tbse_pkg::SAT_POS_MAX)) begin
				sat_d = SW'(tbse_pkg::SAT_POS_MAX);
			end else begin
				sat_d = $signed(q[SW-1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			low_alpha_q   <= tbse_pkg::LOW_ALPHA_RST;
			high_alpha_q  <= tbse_pkg::HIGH_ALPHA_RST;
			low_gain_q    <= tbse_pkg::GAIN_RST;
			mid_gain_q    <= tbse_pkg::GAIN_RST;
			treble_gain_q <= tbse_pkg::GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tbse_pkg::REG_ENABLE:      enable_q      <= cfg_data[0];
				tbse_pkg::REG_LOW_ALPHA:   low_alpha_q   <= cfg_data[tbse_pkg::ALPHA_W-1:0];
				tbse_pkg::REG_HIGH_ALPHA:  high_alpha_q  <= cfg_data[tbse_pkg::ALPHA_W-1:0];
				tbse_pkg::REG_LOW_GAIN:    low_gain_q    <= cfg_data[tbse_pkg::GAIN_W-1:0];
				tbse_pkg::REG_MID_GAIN:    mid_gain_q    <= cfg_data[tbse_pkg::GAIN_W-1:0];
				tbse_pkg::REG_TREBLE_GAIN: treble_gain_q <= cfg_data[tbse_pkg::GAIN_W-1:0];
				default:                   enable_q      <= enable_q;
			endcase
		end
	end

	// crossover state per channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				bass_q[i]  <= '0;
				upper_q[i] <= '0;
			end
		end else begin
			if (cmd.upd_bass) begin
				bass_q[cmd.ch] <= bass_cur + step_d;
			end
			if (cmd.upd_upper) begin
				upper_q[cmd.ch] <= upper_cur + step_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			samp_l_q <= left_sample;
			samp_r_q <= right_sample;
			eob_q    <= end_of_block;
			// pass-through result unless the channel passes are run
			res_l_q  <= left_sample;
			res_r_q  <= right_sample;
		end
		if (cmd.opnd_en) begin
			opnd_q <= opnd_d;
		end
		if (cmd.mul_en) begin
			prod_q <= coef_d * opnd_q;
		end
		if (cmd.acc_clr) begin
			acc_q <= ACC_W'(prod_q);
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
		if (cmd.mag_en) begin
			neg_q <= acc_q[ACC_W-1];
			mag_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		end
		if (cmd.scale_en) begin
			sc_q <= {mag_q, {tbse_pkg::SCALE_BITS{1'b0}}}
				- {{tbse_pkg::SCALE_BITS{1'b0}}, mag_q};
		end
		if (cmd.sat_en) begin
			if (cmd.ch) begin
				res_r_q <= sat_d;
			end else begin
				res_l_q <= sat_d;
			end
		end
		if (cmd.out_load) begin
			left_q    <= res_l_q;
			right_q   <= res_r_q;
			eob_out_q <= eob_q;
		end
	end

endmodule

`default_nettype wire

### src/three_band_stereo_equalizer_top.sv
// three-band stereo equalizer with one-pole crossovers, top level
// joins the sequencer tbse_ctrl and the datapath tbse_dp; uses tbse_pkg
`default_nettype none

// One stereo word in, one equalized stereo word out. With enable set a word
// is accepted in idle, runs eleven steps per channel through the single
// shared multiplier (two crossover updates, three band gains, magnitude,
// scale, saturate), then waits in the hand-off to the output register while
// the output is stalled; the next word is accepted once back in idle. With
// enable clear a word goes to the hand-off and the filter state is untouched.
// The output register holds a finished word while the next one is taken in
// and worked on. Configuration writes are meant for idle periods only.
module three_band_stereo_equalizer_top #(
	parameter int COEF_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [tbse_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [tbse_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [tbse_pkg::SAMPLE_W-1:0] left_sample,
	input  wire logic signed [tbse_pkg::SAMPLE_W-1:0] right_sample,
	input  wire logic                                 end_of_block,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [tbse_pkg::SAMPLE_W-1:0]      left_result,
	output logic signed [tbse_pkg::SAMPLE_W-1:0]      right_result,
	output logic                                      end_of_block_out
);

	tbse_pkg::cmd_t  cmd;
	tbse_pkg::stat_t stat;

	tbse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	tbse_dp #(
		.COEF_BITS (COEF_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.left_sample      (left_sample),
		.right_sample     (right_sample),
		.end_of_block     (end_of_block),
		.cmd              (cmd),
		.stat             (stat),
		.left_result      (left_result),
		.right_result     (right_result),
		.end_of_block_out (end_of_block_out)
	);

endmodule

`default_nettype wire
